FILE: rtl/les_pkg.sv
// shared types and constants of the led effect sequencer
// no dependencies; imported by the channel interfaces and the top level
package les_pkg;

    // mode codes
    localparam logic [1:0] MODE_GLINT   = 2'd0;
    localparam logic [1:0] MODE_SHUFFLE = 2'd1;
    localparam logic [1:0] MODE_SCANNER = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_STEP_DELAY   = 2'd0;
    localparam logic [1:0] CFG_IDLE_LEVEL   = 2'd1;
    localparam logic [1:0] CFG_BRIGHT_LEVEL = 2'd2;
    localparam logic [1:0] CFG_TOUCH_LEVEL  = 2'd3;

    // register reset values
    localparam logic [7:0] RST_STEP_DELAY   = 8'd100;
    localparam logic [7:0] RST_IDLE_LEVEL   = 8'd14;
    localparam logic [7:0] RST_BRIGHT_LEVEL = 8'd196;
    localparam logic [7:0] RST_TOUCH_LEVEL  = 8'd184;

    localparam int          NUM_LEDS     = 3;
    localparam logic [2:0]  RAMP_TOP     = 3'd6;
    localparam logic [7:0]  TWINKLE_DEC  = 8'd5;
    localparam logic [1:0]  SCAN_BACK    = 2'd3;
    localparam logic [1:0]  PICK_INVALID = 2'd3;

    typedef logic [7:0] t_level;

    localparam t_level LOG_TABLE [8] = '{
        8'd30, 8'd43, 8'd59, 8'd78, 8'd102, 8'd137, 8'd196, 8'd255
    };

    typedef struct packed {
        logic       measure_done;
        logic       key_touched;
        logic       twinkle_start;
        logic [1:0] twinkle_pick;
        t_level     random_level_a;
        t_level     random_level_b;
        t_level     random_level_c;
    } t_in_item;

    typedef struct packed {
        t_level     led_level_a;
        t_level     led_level_b;
        t_level     led_level_c;
        logic [1:0] current_mode;
    } t_out_item;

    typedef struct packed {
        t_level step_delay;
        t_level idle_level;
        t_level bright_level;
        t_level touch_level;
    } t_cfg_regs;

endpackage

FILE: rtl/les_if.sv
// valid/ready channel interfaces of the led effect sequencer
// depends on les_pkg for the item types
interface les_in_if import les_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface les_out_if import les_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface les_cfg_if import les_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    t_level     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/led_effect_sequencer.sv
// led effect sequencer top level: mode control, pattern state and output stage
// depends on les_pkg and the channel interfaces in les_if.sv

// One item per 1 ms tick goes in, and one item of three LED levels plus the
// current mode comes out for every item accepted. The block takes one item
// every clock cycle while the skid register is empty: the whole state update
// is a single pass of narrow logic from the state registers to their next
// values, and the result is registered in the output stage. The output side
// holds two results (output register plus skid register), so input ready
// depends only on the skid register and a stalled consumer holds up the
// input only once two results are waiting. Configuration writes are always
// taken (ready stays high) and should only be made while the block is idle.
// Releasing the touch key steps the mode twinkle, random, scanner, twinkle;
// while the key is held every LED shows touch_level.
module led_effect_sequencer import les_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    les_in_if.sink      i_in,
    les_out_if.source   o_out,
    les_cfg_if.sink     i_cfg
);

    // configuration registers
    t_cfg_regs r_cfg;

    // pattern state
    logic [1:0] r_mode, n_mode;
    logic       r_touch_held, n_touch_held;
    logic       r_mode_changed, n_mode_changed;
    t_level     r_level [NUM_LEDS];
    t_level     n_level [NUM_LEDS];
    logic [2:0] r_ramp_pos, n_ramp_pos;
    logic       r_ramp_up, n_ramp_up;
    logic       r_twk_active, n_twk_active;
    logic [1:0] r_twk_idx, n_twk_idx;
    t_level     r_countdown, n_countdown;
    logic [1:0] r_scan_step, n_scan_step;

    // output stage
    logic      r_main_v, r_skid_v;
    t_out_item r_main, r_skid;
    t_out_item w_result;

    logic w_accept, w_pop;
    logic [1:0] w_idx, w_lit;

    assign i_in.ready  = !r_skid_v;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_pop       = r_main_v && o_out.ready;

    assign o_out.valid = r_main_v;
    assign o_out.data  = r_main;

    // next state for the item at the input
    always_comb begin
        n_mode         = r_mode;
        n_touch_held   = r_touch_held;
        n_mode_changed = r_mode_changed;
        n_level        = r_level;
        n_ramp_pos     = r_ramp_pos;
        n_ramp_up      = r_ramp_up;
        n_twk_active   = r_twk_active;
        n_twk_idx      = r_twk_idx;
        n_countdown    = r_countdown;
        n_scan_step    = r_scan_step;
        w_idx          = 2'd0;
        w_lit          = 2'd0;

        // key release advances the mode
        if (i_in.data.measure_done) begin
            if (i_in.data.key_touched) begin
                n_touch_held = 1'b1;
            end else if (r_touch_held) begin
                case (r_mode)
                    MODE_GLINT:   n_mode = MODE_SHUFFLE;
                    MODE_SHUFFLE: n_mode = MODE_SCANNER;
                    default:      n_mode = MODE_GLINT;
                endcase
                n_touch_held   = 1'b0;
                n_mode_changed = 1'b1;
            end
        end

        if (!n_touch_held) begin
            // first untouched tick after a mode change starts from scratch
            if (n_mode_changed) begin
                n_level        = '{default: r_cfg.idle_level};
                n_ramp_pos     = 3'd0;
                n_ramp_up      = 1'b1;
                n_twk_active   = 1'b0;
                n_scan_step    = 2'd0;
                n_countdown    = 8'd0;
                n_mode_changed = 1'b0;
            end

            case (n_mode)
                MODE_GLINT: begin
                    if (!n_twk_active && i_in.data.twinkle_start) begin
                        n_twk_active = 1'b1;
                        n_twk_idx    = (i_in.data.twinkle_pick == PICK_INVALID) ?
                                       2'd0 : i_in.data.twinkle_pick;
                    end
                    if (n_countdown == 8'd0 && n_twk_active) begin
                        w_idx = (n_twk_idx == PICK_INVALID) ? 2'd0 : n_twk_idx;
                        if (n_ramp_up) begin
                            n_level[w_idx] = LOG_TABLE[n_ramp_pos];
                            n_ramp_pos     = n_ramp_pos + 3'd1;
                            if (n_ramp_pos == RAMP_TOP) begin
                                n_ramp_up = 1'b0;
                            end
                        end else begin
                            n_ramp_pos     = n_ramp_pos - 3'd1;
                            n_level[w_idx] = LOG_TABLE[n_ramp_pos];
                            // back at the bottom: twinkle done
                            if (n_ramp_pos == 3'd0) begin
                                n_ramp_up    = 1'b1;
                                n_twk_active = 1'b0;
                                n_level      = '{default: r_cfg.idle_level};
                            end
                        end
                        n_countdown = r_cfg.step_delay;
                    end else begin
                        // wraps modulo 256, also while idle
                        n_countdown = n_countdown - TWINKLE_DEC;
                    end
                end
                MODE_SHUFFLE: begin
                    if (n_countdown == 8'd0) begin
                        n_level[0]  = i_in.data.random_level_a;
                        n_level[1]  = i_in.data.random_level_b;
                        n_level[2]  = i_in.data.random_level_c;
                        n_countdown = r_cfg.step_delay;
                    end else begin
                        n_countdown = n_countdown - 8'd1;
                    end
                end
                MODE_SCANNER: begin
                    if (n_countdown == 8'd0) begin
                        // lit led walks 0, 1, 2, 1
                        w_lit          = (n_scan_step == SCAN_BACK) ? 2'd1 : n_scan_step;
                        n_level        = '{default: r_cfg.idle_level};
                        n_level[w_lit] = r_cfg.bright_level;
                        n_scan_step    = n_scan_step + 2'd1;
                        n_countdown    = r_cfg.step_delay;
                    end else begin
                        n_countdown = n_countdown - 8'd1;
                    end
                end
                default: begin
                    // unused mode code: no pattern runs
                end
            endcase
        end else begin
            n_level = '{default: r_cfg.touch_level};
        end

        w_result.led_level_a  = n_level[0];
        w_result.led_level_b  = n_level[1];
        w_result.led_level_c  = n_level[2];
        w_result.current_mode = n_mode;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay   <= RST_STEP_DELAY;
            r_cfg.idle_level   <= RST_IDLE_LEVEL;
            r_cfg.bright_level <= RST_BRIGHT_LEVEL;
            r_cfg.touch_level  <= RST_TOUCH_LEVEL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_STEP_DELAY:   r_cfg.step_delay   <= i_cfg.data;
                CFG_IDLE_LEVEL:   r_cfg.idle_level   <= i_cfg.data;
                CFG_BRIGHT_LEVEL: r_cfg.bright_level <= i_cfg.data;
                CFG_TOUCH_LEVEL:  r_cfg.touch_level  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // pattern state, updated once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_GLINT;
            r_touch_held   <= 1'b0;
            r_mode_changed <= 1'b0;
            r_level        <= '{default: RST_IDLE_LEVEL};
            r_ramp_pos     <= 3'd0;
            r_ramp_up      <= 1'b1;
            r_twk_active   <= 1'b0;
            r_twk_idx      <= 2'd0;
            r_countdown    <= 8'd0;
            r_scan_step    <= 2'd0;
        end else if (w_accept) begin
            r_mode         <= n_mode;
            r_touch_held   <= n_touch_held;
            r_mode_changed <= n_mode_changed;
            r_level        <= n_level;
            r_ramp_pos     <= n_ramp_pos;
            r_ramp_up      <= n_ramp_up;
            r_twk_active   <= n_twk_active;
            r_twk_idx      <= n_twk_idx;
            r_countdown    <= n_countdown;
            r_scan_step    <= n_scan_step;
        end
    end

    // output register plus skid register, results leave in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= w_accept;
            end
        end else if (!r_main_v) begin
            r_main_v <= w_accept;
        end else if (w_accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else if (w_accept) begin
                r_main <= w_result;
            end
        end else if (!r_main_v) begin
            if (w_accept) begin
                r_main <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    // skid register only fills behind a waiting result
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid result without output result");

    // an item taken into an empty output stage shows up next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_main_v) |=> r_main_v)
        else $error("accepted item produced no result");

    // with no twinkle running the ramp sits at the bottom going up
    a_ramp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_twk_active |-> (r_ramp_pos == 3'd0 && r_ramp_up))
        else $error("ramp left mid-way without an active twinkle");

    // chosen led is always one of the three
    a_twk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_twk_idx != PICK_INVALID)
        else $error("twinkle led index out of range");

endmodule
